[rtl/ptsb_pkg.sv]
// Shared types, codes and constants of the periodic timer slot bank.
package ptsb_pkg;

  // Default size of the slot bank
  localparam int unsigned SLOT_COUNT_DEF = 15;
  // Most fired slots reported by one scan
  localparam int unsigned MAX_RESULTS    = 15;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned BASE_W  = 24;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned STAT_W  = 2;

  // Quotient bits produced by the serial divider, one per cycle
  localparam int unsigned DIV_STEPS = BASE_W;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1000);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_CHANGE = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_SCAN   = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_NOT_ALLOC = 2'd2,
    STAT_ZERO_RATE = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    logic    div_start;
    logic    idx_inc;
    logic    tick_rd;
    logic    write_entry;
    logic    set_run;
    logic    stop_slot;
    logic    emit_single;
    logic    emit_scan;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              rate_zero;
    logic              slot_ok;
    logic              occ_at_idx;
    logic              fired_at_idx;
    logic              idx_last;
    logic              any_fired;
    logic              scan_last;
    logic              div_done;
  } sts_t;

endpackage

[rtl/ptsb_div.sv]
// Restoring serial divider: one quotient bit per cycle.
module ptsb_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ptsb_pkg::BASE_W-1:0]       dividend_i,
  input  logic [ptsb_pkg::RATE_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [ptsb_pkg::COUNT_W-1:0]      quot_o
);

  localparam int unsigned DVD_W  = ptsb_pkg::BASE_W;
  localparam int unsigned DSR_W  = ptsb_pkg::RATE_W;
  localparam int unsigned STEP_W = $clog2(ptsb_pkg::DIV_STEPS + 1);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DSR_W-1:0]  rem_q;
  logic [DSR_W-1:0]  dsr_q;

  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // Sequence the steps and flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(ptsb_pkg::DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[ptsb_pkg::COUNT_W-1:0];

endmodule

[rtl/ptsb_datapath.sv]
// Datapath: slot flags, countdown/reload memory, divider, index walk and result register.
module ptsb_datapath #(
  parameter int unsigned SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ptsb_pkg::MODE_W-1:0]   mode_i,
  input  logic [ptsb_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptsb_pkg::RATE_W-1:0]   rate_hz_i,
  input  logic                          cfg_we_i,
  input  logic [ptsb_pkg::BASE_W-1:0]   cfg_wdata_i,
  input  ptsb_pkg::cmd_t                cmd_i,
  output ptsb_pkg::sts_t                sts_o,
  output logic                          res_strobe_o,
  output logic [ptsb_pkg::STAT_W-1:0]   status_o,
  output logic [ptsb_pkg::SLOT_W-1:0]   slot_out_o,
  output logic                          fired_valid_o,
  output logic                          last_o
);

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SCNT_W = $clog2(ptsb_pkg::MAX_RESULTS + 1);
  localparam int unsigned CW     = ptsb_pkg::COUNT_W;
  localparam int unsigned SW     = ptsb_pkg::SLOT_W;

  // Configuration and latched item
  logic [ptsb_pkg::BASE_W-1:0] base_q;
  logic [ptsb_pkg::MODE_W-1:0] mode_q;
  logic [ptsb_pkg::RATE_W-1:0] rate_q;
  logic                        in_range_q;

  // Walk index and scan count
  logic [IDX_W-1:0]  idx_q;
  logic [SCNT_W-1:0] scnt_q;

  // Per-slot flags
  logic [SLOT_COUNT-1:0] occ_q;
  logic [SLOT_COUNT-1:0] run_q;
  logic [SLOT_COUNT-1:0] fired_q;

  // Entry memory: reload in the upper half, countdown in the lower half
  logic [2*CW-1:0] mem [SLOT_COUNT];
  logic [2*CW-1:0] rd_q;
  logic            pipe_vld_q;
  logic [IDX_W-1:0] pipe_idx_q;

  // Result register
  logic                        res_strobe_q;
  logic [ptsb_pkg::STAT_W-1:0] status_q;
  logic [SW-1:0]               slot_out_q;
  logic                        fired_valid_q;
  logic                        last_q;

  logic [IDX_W+SW-1:0]   slot_wide;
  logic [IDX_W+SW-1:0]   idx_wide;
  logic [SLOT_COUNT-1:0] above;
  logic                  more_fired;
  logic                  scan_last;
  logic                  add_mode;
  logic [CW-1:0]         cd_dec;
  logic [CW-1:0]         reload;
  logic                  tick_hit;
  logic                  tick_wrap;
  logic                  div_done;
  logic [CW-1:0]         quot;

  ptsb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (base_q),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Widen the slot and the index for either direction of narrowing
  assign slot_wide = {{IDX_W{1'b0}}, slot_i};
  assign idx_wide  = {{SW{1'b0}}, idx_q};
  assign add_mode  = (mode_q == ptsb_pkg::MODE_ADD);

  // Mark the slots above the current index
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      above[i] = (IDX_W'(i) > idx_q);
    end
  end

  assign more_fired = |(fired_q & above);
  assign scan_last  = !more_fired || (scnt_q == SCNT_W'(ptsb_pkg::MAX_RESULTS - 1));

  // Tick arithmetic on the entry read last cycle
  assign reload    = rd_q[2*CW-1:CW];
  assign cd_dec    = rd_q[CW-1:0] - CW'(1);
  assign tick_hit  = pipe_vld_q && run_q[pipe_idx_q];
  assign tick_wrap = (cd_dec == '0);

  // Report status to the controller
  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.rate_zero    = (rate_q == '0);
    sts_o.slot_ok      = in_range_q && occ_q[idx_q];
    sts_o.occ_at_idx   = occ_q[idx_q];
    sts_o.fired_at_idx = fired_q[idx_q];
    sts_o.idx_last     = (idx_q == IDX_W'(SLOT_COUNT - 1));
    sts_o.any_fired    = |fired_q;
    sts_o.scan_last    = scan_last;
    sts_o.div_done     = div_done;
  end

  // Hold the base rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ptsb_pkg::BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Latch the item, walk the index, count scan beats
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q     <= mode_i;
      rate_q     <= rate_hz_i;
      in_range_q <= (32'(slot_i) < 32'(SLOT_COUNT));
      scnt_q     <= '0;
      if (mode_i == ptsb_pkg::MODE_CHANGE || mode_i == ptsb_pkg::MODE_RESUME ||
          mode_i == ptsb_pkg::MODE_STOP) begin
        idx_q <= slot_wide[IDX_W-1:0];
      end else begin
        idx_q <= '0;
      end
    end else begin
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.emit_scan) begin
        scnt_q <= scnt_q + SCNT_W'(1);
      end
    end
  end

  // Update slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      run_q   <= '0;
      fired_q <= '0;
    end else begin
      if (cmd_i.write_entry && add_mode) begin
        occ_q[idx_q]   <= 1'b1;
        run_q[idx_q]   <= 1'b1;
        fired_q[idx_q] <= 1'b0;
      end
      if (cmd_i.set_run) begin
        run_q[idx_q] <= 1'b1;
      end
      if (cmd_i.stop_slot) begin
        run_q[idx_q]   <= 1'b0;
        fired_q[idx_q] <= 1'b0;
      end
      if (cmd_i.emit_scan) begin
        fired_q[idx_q] <= 1'b0;
      end
      if (tick_hit && tick_wrap) begin
        fired_q[pipe_idx_q] <= 1'b1;
      end
    end
  end

  // Read pipeline valid for the tick walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
    end else begin
      pipe_vld_q <= cmd_i.tick_rd;
    end
  end

  // Entry memory: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_rd) begin
      rd_q       <= mem[idx_q];
      pipe_idx_q <= idx_q;
    end
    if (tick_hit) begin
      mem[pipe_idx_q] <= tick_wrap ? {reload, reload} : {reload, cd_dec};
    end else if (cmd_i.write_entry) begin
      mem[idx_q] <= {quot, quot};
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= cmd_i.emit_single || cmd_i.emit_scan;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_scan) begin
      status_q      <= ptsb_pkg::STAT_OK;
      slot_out_q    <= idx_wide[SW-1:0];
      fired_valid_q <= 1'b1;
      last_q        <= scan_last;
    end else if (cmd_i.emit_single) begin
      status_q      <= cmd_i.status;
      slot_out_q    <= (add_mode && cmd_i.status == ptsb_pkg::STAT_OK) ?
                       idx_wide[SW-1:0] : '0;
      fired_valid_q <= 1'b0;
      last_q        <= 1'b1;
    end
  end

  assign res_strobe_o  = res_strobe_q;
  assign status_o      = status_q;
  assign slot_out_o    = slot_out_q;
  assign fired_valid_o = fired_valid_q;
  assign last_o        = last_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tick_hit && cmd_i.write_entry))
    else $error("tick write-back collides with entry write");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_scan |=> !fired_q[$past(idx_q)])
    else $error("reported slot still flagged as fired");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_q && !fired_valid_q) |-> last_q)
    else $error("non-scan beat without last");

endmodule

[rtl/ptsb_ctrl.sv]
// Controller: sequences each command through decode and then its search, divide, tick, scan or response states.
module ptsb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ptsb_pkg::sts_t sts_i,
  output ptsb_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_WRITE  = 9'b000010000,
    S_TICK   = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_SCAN   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  ptsb_pkg::status_e resp_q, resp_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_d  = ptsb_pkg::STAT_OK;
        state_d = S_RESP;
        unique case (sts_i.mode)
          ptsb_pkg::MODE_TICK: begin
            state_d = S_TICK;
          end
          ptsb_pkg::MODE_ADD: begin
            if (sts_i.rate_zero) begin
              resp_d = ptsb_pkg::STAT_ZERO_RATE;
            end else begin
              state_d = S_SEARCH;
            end
          end
          ptsb_pkg::MODE_CHANGE: begin
            if (!sts_i.slot_ok) begin
              resp_d = ptsb_pkg::STAT_NOT_ALLOC;
            end else if (sts_i.rate_zero) begin
              resp_d = ptsb_pkg::STAT_ZERO_RATE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          ptsb_pkg::MODE_RESUME: begin
            if (!sts_i.slot_ok) begin
              resp_d = ptsb_pkg::STAT_NOT_ALLOC;
            end else begin
              cmd_o.set_run = 1'b1;
            end
          end
          ptsb_pkg::MODE_STOP: begin
            if (!sts_i.slot_ok) begin
              resp_d = ptsb_pkg::STAT_NOT_ALLOC;
            end else begin
              cmd_o.stop_slot = 1'b1;
            end
          end
          ptsb_pkg::MODE_SCAN: begin
            if (sts_i.any_fired) begin
              state_d = S_SCAN;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SEARCH: begin
        // Stop at the first free slot, give up after the last one
        priority if (!sts_i.occ_at_idx) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.idx_last) begin
          resp_d  = ptsb_pkg::STAT_NO_SLOT;
          state_d = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_entry = 1'b1;
        resp_d            = ptsb_pkg::STAT_OK;
        state_d           = S_RESP;
      end
      S_TICK: begin
        cmd_o.tick_rd = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        resp_d  = ptsb_pkg::STAT_OK;
        state_d = S_RESP;
      end
      S_SCAN: begin
        // Report each fired slot in order, finish on the final beat or at the last slot
        if (sts_i.fired_at_idx) begin
          cmd_o.emit_scan = 1'b1;
          if (sts_i.scan_last) begin
            state_d = S_IDLE;
          end
        end
        if (sts_i.idx_last) begin
          state_d = S_IDLE;
        end
        cmd_o.idx_inc = 1'b1;
      end
      S_RESP: begin
        cmd_o.emit_single = 1'b1;
        cmd_o.status      = resp_q;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ptsb_pkg::STAT_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DECODE))
    else $error("accepted command did not reach decode");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_resp_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> (state_q == S_IDLE))
    else $error("response state did not return to idle");

endmodule

[rtl/periodic_timer_slot_bank_core.sv]
// Top level of the periodic timer slot bank: controller plus datapath.
//
// A command is taken when start is high and busy is low; busy stays high
// until its last result has been registered. Results appear as one-cycle
// beats marked by res_strobe_o and cannot be held off, so the receiver must
// capture every strobed beat. Tick makes one memory read per slot from the
// countdown/reload memory; add runs a one-slot-per-cycle free-slot search,
// then the bit-serial divider and the entry write; change rate runs the
// divider and the entry write; resume, stop, the unused modes and rejected
// commands go from decode to the response, except an add into a full table,
// which searches every slot first; a scan with a fired slot examines the
// slots in order, one slot per cycle, each reported slot leaving one beat.
// base_tick_rate is written through cfg_we_i/cfg_wdata_i and must only
// change while busy is low.
module periodic_timer_slot_bank_core #(
  parameter int unsigned SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptsb_pkg::MODE_W-1:0]   mode_i,
  input  logic [ptsb_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptsb_pkg::RATE_W-1:0]   rate_hz_i,
  input  logic                          cfg_we_i,
  input  logic [ptsb_pkg::BASE_W-1:0]   cfg_wdata_i,
  output logic                          res_strobe_o,
  output logic [ptsb_pkg::STAT_W-1:0]   status_o,
  output logic [ptsb_pkg::SLOT_W-1:0]   slot_out_o,
  output logic                          fired_valid_o,
  output logic                          last_o
);

  ptsb_pkg::cmd_t cmd;
  ptsb_pkg::sts_t sts;

  ptsb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ptsb_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .rate_hz_i     (rate_hz_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_strobe_o  (res_strobe_o),
    .status_o      (status_o),
    .slot_out_o    (slot_out_o),
    .fired_valid_o (fired_valid_o),
    .last_o        (last_o)
  );

endmodule
